>>> hw/rtl/lfps_pkg.sv
// Shared types and constants of the line follower steering block.
`default_nettype none

package lfps_pkg;

   // Fixed field widths of the channels.
   localparam int FLAGS_W     = 8;
   localparam int DEV_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int BASE_W      = 8;
   localparam int SPEED_W     = 9;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Internal arithmetic widths that follow from the fixed fields.
   localparam int ERR_W      = DEV_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int CORR_MAG_W = 13;
   localparam int CORR_W     = CORR_MAG_W + 1;
   localparam int SPD_CALC_W = CORR_W + 1;

   // Speed window and correction limit.
   localparam int SPEED_HEADROOM = 20;
   localparam int SPEED_FLOOR    = 10;
   localparam int PIVOT_BOOST    = 10;
   localparam int CORR_LIMIT     = 4096;

   // Flag bit positions of a sensor frame.
   localparam int FLAG_SIGN    = 0;
   localparam int FLAG_ON_LINE = 1;
   localparam int FLAG_SIDE    = 2;
   localparam int FLAG_FULL    = 3;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_BASE_SPEED = csr_index_type'(0);
   localparam csr_index_type REG_PROP_GAIN  = csr_index_type'(1);
   localparam csr_index_type REG_INTEG_GAIN = csr_index_type'(2);
   localparam csr_index_type REG_DERIV_GAIN = csr_index_type'(3);

   typedef enum logic [1:0] {
      TRACK_IDLE    = 2'd0,
      TRACK_ON      = 2'd1,
      TRACK_PIVOT_L = 2'd2,
      TRACK_PIVOT_R = 2'd3
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/lfps_if.sv
// Channel interfaces of the line follower steering block.
`default_nettype none

interface lfps_req_if;
   logic                        valid;
   logic                        ready;
   logic [lfps_pkg::FLAGS_W-1:0] sensor_flags;
   logic [lfps_pkg::DEV_W-1:0]   deviation;
   logic                        turn_enable;

   modport source (output valid, output sensor_flags, output deviation,
                   output turn_enable, input ready);
   modport sink   (input valid, input sensor_flags, input deviation,
                   input turn_enable, output ready);
endinterface

interface lfps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        speed_valid;
   logic [lfps_pkg::SPEED_W-1:0] left_speed;
   logic [lfps_pkg::SPEED_W-1:0] right_speed;
   logic [1:0]                  track_status;

   modport source (output valid, output speed_valid, output left_speed,
                   output right_speed, output track_status, input ready);
   modport sink   (input valid, input speed_valid, input left_speed,
                   input right_speed, input track_status, output ready);
endinterface

interface lfps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lfps_pkg::CSR_INDEX_W-1:0] index;
   logic [lfps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/line_follow_pid_steer.sv
// Top level: PID steering of a differential drive from decoded line-sensor frames.
// Throughput is one sensor beat per cycle while rsp_if takes results; every beat yields exactly one result beat.
// The accepting edge loads the error and integral stage, and five more register stages
// follow: gain multiplies, two adder levels, the correction limit, and the output register.
// Reset (synchronous, active high) empties the pipeline, clears the integral and the
// last error, and loads base_speed 0, prop_gain 256, integ_gain 0, deriv_gain 0.
`default_nettype none

module line_follow_pid_steer #(
   parameter int SUM_WIDTH      = 32,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lfps_req_if.sink   req_if,
   lfps_rsp_if.source rsp_if,
   lfps_csr_if.sink   csr_if
);

   // The integral product is split in two halves so that no multiplier grows past
   // about 17 by 24 bits at the largest supported integral width.
   localparam int LO_W  = SUM_WIDTH / 2;
   localparam int HI_W  = SUM_WIDTH - LO_W;
   localparam int GS_W  = lfps_pkg::GAIN_W + 1;
   localparam int ILO_W = lfps_pkg::GAIN_W + LO_W;
   localparam int IHI_W = GS_W + HI_W;
   localparam int PE_W  = GS_W + lfps_pkg::ERR_W;
   localparam int DD_W  = GS_W + lfps_pkg::DIFF_W;
   localparam int ACC_W = SUM_WIDTH + lfps_pkg::GAIN_W + 3;

   // ---------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; unknown indexes are dropped.
   // ---------------------------------------------------------------------------
   logic [lfps_pkg::BASE_W-1:0] base_ff;
   logic [lfps_pkg::GAIN_W-1:0] prop_ff;
   logic [lfps_pkg::GAIN_W-1:0] integ_ff;
   logic [lfps_pkg::GAIN_W-1:0] deriv_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         prop_ff  <= lfps_pkg::GAIN_W'(256);
         integ_ff <= '0;
         deriv_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            lfps_pkg::REG_BASE_SPEED: base_ff  <= csr_if.data[lfps_pkg::BASE_W-1:0];
            lfps_pkg::REG_PROP_GAIN:  prop_ff  <= csr_if.data;
            lfps_pkg::REG_INTEG_GAIN: integ_ff <= csr_if.data;
            lfps_pkg::REG_DERIV_GAIN: deriv_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together; it holds only while a result waits.
   logic rsp_valid_ff;
   logic adv;
   logic accept;

   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;
   assign accept       = req_if.valid && adv;

   // ---------------------------------------------------------------------------
   // Input stage: signed error, saturating integral and error difference. The
   // integral and last error live here so that the next beat sees them at once.
   // ---------------------------------------------------------------------------
   logic signed [lfps_pkg::ERR_W-1:0]  dev_s;
   logic signed [lfps_pkg::ERR_W-1:0]  err_in;
   logic signed [SUM_WIDTH:0]          sum_wide;
   logic signed [SUM_WIDTH-1:0]        sum_sat;
   logic signed [lfps_pkg::DIFF_W-1:0] diff_in;
   logic                               track_go;
   lfps_pkg::status_type               st_in;

   logic signed [SUM_WIDTH-1:0]       error_sum_ff;
   logic signed [lfps_pkg::ERR_W-1:0] prev_err_ff;

   assign dev_s  = {1'b0, req_if.deviation};
   assign err_in = req_if.sensor_flags[lfps_pkg::FLAG_SIGN] ? dev_s : -dev_s;

   assign sum_wide = (SUM_WIDTH + 1)'(error_sum_ff) + (SUM_WIDTH + 1)'(err_in);

   // Overflow shows as the two top bits of the widened sum disagreeing.
   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
   end

   assign diff_in = lfps_pkg::DIFF_W'(err_in) - lfps_pkg::DIFF_W'(prev_err_ff);

   // Only a frame that is partly on the line runs the controller.
   assign track_go = accept && req_if.sensor_flags[lfps_pkg::FLAG_ON_LINE]
                     && !req_if.sensor_flags[lfps_pkg::FLAG_FULL];

   always_comb begin
      if (req_if.sensor_flags[lfps_pkg::FLAG_ON_LINE]) begin
         st_in = req_if.sensor_flags[lfps_pkg::FLAG_FULL] ? lfps_pkg::TRACK_IDLE
                                                          : lfps_pkg::TRACK_ON;
      end else if (req_if.turn_enable) begin
         st_in = req_if.sensor_flags[lfps_pkg::FLAG_SIDE] ? lfps_pkg::TRACK_PIVOT_R
                                                          : lfps_pkg::TRACK_PIVOT_L;
      end else begin
         st_in = lfps_pkg::TRACK_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else if (track_go) begin
         error_sum_ff <= sum_sat;
         prev_err_ff  <= err_in;
      end
   end

   logic                               v1_ff;
   lfps_pkg::status_type               st1_ff;
   logic signed [lfps_pkg::ERR_W-1:0]  err1_ff;
   logic signed [SUM_WIDTH-1:0]        sum1_ff;
   logic signed [lfps_pkg::DIFF_W-1:0] diff1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff   <= st_in;
         err1_ff  <= err_in;
         sum1_ff  <= sum_sat;
         diff1_ff <= diff_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Multiply stage. Gains are unsigned, so each gets a zero sign bit.
   // ---------------------------------------------------------------------------
   logic signed [GS_W-1:0]   prop_s;
   logic signed [GS_W-1:0]   integ_s;
   logic signed [GS_W-1:0]   deriv_s;
   logic        [LO_W-1:0]   sum_lo;
   logic signed [HI_W-1:0]   sum_hi;
   logic signed [PE_W-1:0]   pe_in;
   logic signed [DD_W-1:0]   dd_in;
   logic        [ILO_W-1:0]  ilo_in;
   logic signed [IHI_W-1:0]  ihi_in;

   assign prop_s  = {1'b0, prop_ff};
   assign integ_s = {1'b0, integ_ff};
   assign deriv_s = {1'b0, deriv_ff};
   assign sum_lo  = sum1_ff[LO_W-1:0];
   assign sum_hi  = sum1_ff[SUM_WIDTH-1:LO_W];

   assign pe_in  = prop_s * err1_ff;
   assign dd_in  = deriv_s * diff1_ff;
   assign ilo_in = integ_ff * sum_lo;
   assign ihi_in = integ_s * sum_hi;

   logic                     v2_ff;
   lfps_pkg::status_type     st2_ff;
   logic signed [PE_W-1:0]   pe2_ff;
   logic signed [DD_W-1:0]   dd2_ff;
   logic        [ILO_W-1:0]  ilo2_ff;
   logic signed [IHI_W-1:0]  ihi2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st2_ff  <= st1_ff;
         pe2_ff  <= pe_in;
         dd2_ff  <= dd_in;
         ilo2_ff <= ilo_in;
         ihi2_ff <= ihi_in;
      end
   end

   // ---------------------------------------------------------------------------
   // First adder level: rebuild the integral term, and add P and D terms.
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] ihi_ext;
   logic signed [ACC_W-1:0] ip_in;
   logic signed [ACC_W-1:0] pd_in;

   assign ihi_ext = ACC_W'(ihi2_ff);
   assign ip_in   = (ihi_ext <<< LO_W) + ACC_W'(ilo2_ff);
   assign pd_in   = ACC_W'(pe2_ff) + ACC_W'(dd2_ff);

   logic                    v3_ff;
   lfps_pkg::status_type    st3_ff;
   logic signed [ACC_W-1:0] ip3_ff;
   logic signed [ACC_W-1:0] pd3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st3_ff <= st2_ff;
         ip3_ff <= ip_in;
         pd3_ff <= pd_in;
      end
   end

   // Second adder level: the full signed accumulator, Q42.8 plus sign at the default parameters.
   logic                    v4_ff;
   lfps_pkg::status_type    st4_ff;
   logic signed [ACC_W-1:0] acc4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st4_ff  <= st3_ff;
         acc4_ff <= ip3_ff + pd3_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Correction: drop the fraction on the magnitude so that it truncates toward
   // zero, then limit it so the speed arithmetic stays narrow.
   // ---------------------------------------------------------------------------
   logic        [ACC_W-1:0]               acc_mag;
   logic        [ACC_W-1:0]               acc_int;
   logic        [lfps_pkg::CORR_MAG_W-1:0] corr_mag;
   logic signed [lfps_pkg::CORR_W-1:0]     corr_in;

   assign acc_mag = acc4_ff[ACC_W-1] ? -acc4_ff : acc4_ff;
   assign acc_int = acc_mag >> GAIN_FRAC_BITS;

   always_comb begin
      if (acc_int > ACC_W'(lfps_pkg::CORR_LIMIT)) begin
         corr_mag = lfps_pkg::CORR_MAG_W'(lfps_pkg::CORR_LIMIT);
      end else begin
         corr_mag = acc_int[lfps_pkg::CORR_MAG_W-1:0];
      end
   end

   assign corr_in = acc4_ff[ACC_W-1] ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});

   logic                                v5_ff;
   lfps_pkg::status_type                st5_ff;
   logic signed [lfps_pkg::CORR_W-1:0]  corr5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st5_ff   <= st4_ff;
         corr5_ff <= corr_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Wheel speeds and the result register.
   // ---------------------------------------------------------------------------
   function automatic logic [lfps_pkg::SPEED_W-1:0] clamp_speed(
      input logic signed [lfps_pkg::SPD_CALC_W-1:0] v,
      input logic signed [lfps_pkg::SPD_CALC_W-1:0] hi
   );
      logic signed [lfps_pkg::SPD_CALC_W-1:0] r;
      r = v;
      if (r > hi) r = hi;
      if (r < lfps_pkg::SPD_CALC_W'(lfps_pkg::SPEED_FLOOR)) begin
         r = lfps_pkg::SPD_CALC_W'(lfps_pkg::SPEED_FLOOR);
      end
      return r[lfps_pkg::SPEED_W-1:0];
   endfunction

   logic signed [lfps_pkg::SPD_CALC_W-1:0] base_s;
   logic signed [lfps_pkg::SPD_CALC_W-1:0] corr_s;
   logic signed [lfps_pkg::SPD_CALC_W-1:0] speed_hi;
   logic        [lfps_pkg::SPEED_W-1:0]    pivot_fast;
   logic        [lfps_pkg::SPEED_W-1:0]    floor_speed;
   logic                                   speed_valid_in;
   logic        [lfps_pkg::SPEED_W-1:0]    left_in;
   logic        [lfps_pkg::SPEED_W-1:0]    right_in;

   assign base_s      = lfps_pkg::SPD_CALC_W'(base_ff);
   assign corr_s      = lfps_pkg::SPD_CALC_W'(corr5_ff);
   assign speed_hi    = base_s + lfps_pkg::SPD_CALC_W'(lfps_pkg::SPEED_HEADROOM);
   assign pivot_fast  = lfps_pkg::SPEED_W'(base_ff) + lfps_pkg::SPEED_W'(lfps_pkg::PIVOT_BOOST);
   assign floor_speed = lfps_pkg::SPEED_W'(lfps_pkg::SPEED_FLOOR);

   always_comb begin
      case (st5_ff)
         lfps_pkg::TRACK_ON: begin
            speed_valid_in = 1'b1;
            left_in        = clamp_speed(base_s + corr_s, speed_hi);
            right_in       = clamp_speed(base_s - corr_s, speed_hi);
         end
         lfps_pkg::TRACK_PIVOT_L: begin
            speed_valid_in = 1'b1;
            left_in        = floor_speed;
            right_in       = pivot_fast;
         end
         lfps_pkg::TRACK_PIVOT_R: begin
            speed_valid_in = 1'b1;
            left_in        = pivot_fast;
            right_in       = floor_speed;
         end
         default: begin
            speed_valid_in = 1'b0;
            left_in        = '0;
            right_in       = '0;
         end
      endcase
   end

   logic                           speed_valid_ff;
   logic [lfps_pkg::SPEED_W-1:0]   left_ff;
   logic [lfps_pkg::SPEED_W-1:0]   right_ff;
   lfps_pkg::status_type           status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         speed_valid_ff <= speed_valid_in;
         left_ff        <= left_in;
         right_ff       <= right_in;
         status_ff      <= st5_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.speed_valid  = speed_valid_ff;
   assign rsp_if.left_speed   = left_ff;
   assign rsp_if.right_speed  = right_ff;
   assign rsp_if.track_status = status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lfps_checker.sv
// Port-level checker of the line follower steering block and its bind.
`default_nettype none

module lfps_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         speed_valid,
   input wire logic [lfps_pkg::SPEED_W-1:0] left_speed,
   input wire logic [lfps_pkg::SPEED_W-1:0] right_speed,
   input wire logic [1:0]                   track_status
);

   // A result beat that is not taken stays in place with its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(speed_valid)
         && $stable(left_speed) && $stable(right_speed) && $stable(track_status))
      else $error("result beat changed while stalled");

   // Reset empties the pipeline, so no result follows it directly.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // A tracking command always carries a speed, and neither wheel falls below the speed floor.
   a_track_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && track_status == lfps_pkg::TRACK_ON |->
         speed_valid
         && left_speed >= lfps_pkg::SPEED_W'(lfps_pkg::SPEED_FLOOR)
         && right_speed >= lfps_pkg::SPEED_W'(lfps_pkg::SPEED_FLOOR))
      else $error("tracking speed outside the window");

   // An idle status carries no command and zero speeds.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && track_status == lfps_pkg::TRACK_IDLE |->
         !speed_valid && left_speed == '0 && right_speed == '0)
      else $error("idle result carries a speed");

endmodule

bind line_follow_pid_steer lfps_checker u_lfps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .speed_valid  (rsp_if.speed_valid),
   .left_speed   (rsp_if.left_speed),
   .right_speed  (rsp_if.right_speed),
   .track_status (rsp_if.track_status)
);

`default_nettype wire
